[rtl/psgtn_pkg.sv]
package psgtn_pkg;

    // Field and register widths
    localparam int DATA_W   = 8;
    localparam int CFG_W    = 16;
    localparam int SAMPLE_W = 16;
    localparam int TONE_W   = 10;
    localparam int NPER_W   = 11;
    localparam int CNT_W    = 11;
    localparam int CODE_W   = 4;
    localparam int VOL_W    = 13;
    localparam int SUM_W    = 15;
    localparam int NUM_TONE = 3;
    localparam int NUM_CHAN = 4;

    // Default tick divider
    localparam int DIVIDER_DEF = 8;

    // Configuration reset values
    localparam logic [CFG_W-1:0] LFSR_MASK_RST = 16'h8000;
    localparam logic [CFG_W-1:0] TAP_A_RST     = 16'h0001;
    localparam logic [CFG_W-1:0] TAP_B_RST     = 16'h0008;

    // Input kinds (tuser)
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // Chip register numbers
    localparam logic [2:0] REG_NOISE     = 3'd6;
    localparam logic [2:0] REG_TONE2     = 3'd4;
    localparam logic [2:0] LATCH_IDX_RST = 3'd3;

    // Noise rate code that follows tone channel 2
    localparam logic [1:0] RATE_TONE2 = 2'd3;

    // Volume code of a silent channel
    localparam logic [CODE_W-1:0] VOL_OFF = 4'd15;

    // Configuration register index
    typedef enum logic [1:0] {
        CFG_LFSR_MASK = 2'd0,
        CFG_TAP_A     = 2'd1,
        CFG_TAP_B     = 2'd2
    } t_cfg_reg;

    // Control handed from register decode to the oscillators
    typedef struct packed {
        logic [NUM_TONE-1:0][TONE_W-1:0] tone_period;
        logic [NPER_W-1:0]               noise_period;
        logic                            tap_b_en;
        logic                            noise_load;
    } t_ctrl;

    // 2 dB attenuation steps
    function automatic logic [VOL_W-1:0] vol_level(input logic [CODE_W-1:0] code);
        logic [VOL_W-1:0] v;
        case (code)
            4'd0:    v = 13'd8191;
            4'd1:    v = 13'd6506;
            4'd2:    v = 13'd5168;
            4'd3:    v = 13'd4105;
            4'd4:    v = 13'd3260;
            4'd5:    v = 13'd2590;
            4'd6:    v = 13'd2057;
            4'd7:    v = 13'd1634;
            4'd8:    v = 13'd1298;
            4'd9:    v = 13'd1031;
            4'd10:   v = 13'd819;
            4'd11:   v = 13'd650;
            4'd12:   v = 13'd516;
            4'd13:   v = 13'd410;
            4'd14:   v = 13'd326;
            default: v = 13'd0;
        endcase
        return v;
    endfunction

    // Noise period from the rate bits and tone channel 2 period
    function automatic logic [NPER_W-1:0] noise_period(input logic [1:0] rate,
                                                       input logic [TONE_W-1:0] tone2);
        logic [NPER_W-1:0] p;
        case (rate)
            2'd0:    p = 11'd32;
            2'd1:    p = 11'd64;
            2'd2:    p = 11'd128;
            default: p = {tone2, 1'b0};
        endcase
        return p;
    endfunction

endpackage

[rtl/psgtn_ctrl.sv]
module psgtn_ctrl (
    input  logic                                                    i_clk,
    input  logic                                                    i_rst_n,
    input  logic                                                    i_wr,
    input  logic [psgtn_pkg::DATA_W-1:0]                            i_data,
    output psgtn_pkg::t_ctrl                                        o_ctrl,
    output logic [psgtn_pkg::NUM_CHAN-1:0][psgtn_pkg::CODE_W-1:0]   o_vol_next
);

    logic [2:0]                                                  r_latched;
    logic [2:0]                                                  n_latched;
    logic [psgtn_pkg::NUM_TONE-1:0][psgtn_pkg::TONE_W-1:0]       r_tone;
    logic [psgtn_pkg::NUM_TONE-1:0][psgtn_pkg::TONE_W-1:0]       n_tone;
    logic [psgtn_pkg::NPER_W-1:0]                                r_nper;
    logic [psgtn_pkg::NPER_W-1:0]                                n_nper;
    logic [3:0]                                                  r_noise_reg;
    logic [3:0]                                                  n_noise_reg;
    logic [psgtn_pkg::NUM_CHAN-1:0][psgtn_pkg::CODE_W-1:0]       r_vol;
    logic [psgtn_pkg::NUM_CHAN-1:0][psgtn_pkg::CODE_W-1:0]       n_vol;
    logic                                                        is_latch;
    logic [2:0]                                                  sel;
    logic                                                        noise_load;

    // Decode of one chip byte
    always_comb begin
        n_latched   = r_latched;
        n_tone      = r_tone;
        n_nper      = r_nper;
        n_noise_reg = r_noise_reg;
        n_vol       = r_vol;
        noise_load  = 1'b0;
        is_latch    = i_data[7];
        sel         = is_latch ? i_data[6:4] : r_latched;
        if (i_wr) begin
            if (is_latch) begin
                n_latched = i_data[6:4];
            end
            if (sel == psgtn_pkg::REG_NOISE) begin
                n_noise_reg = i_data[3:0];
                n_nper      = psgtn_pkg::noise_period(n_noise_reg[1:0], r_tone[2]);
                noise_load  = 1'b1;
            end else if (sel[0]) begin
                // volume: both byte forms set the code directly
                n_vol[sel[2:1]] = i_data[3:0];
            end else begin
                if (is_latch) begin
                    n_tone[sel[2:1]][3:0] = i_data[3:0];
                end else begin
                    n_tone[sel[2:1]][9:4] = i_data[5:0];
                end
                if (sel == psgtn_pkg::REG_TONE2 &&
                    r_noise_reg[1:0] == psgtn_pkg::RATE_TONE2) begin
                    n_nper = psgtn_pkg::noise_period(r_noise_reg[1:0], n_tone[2]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latched   <= psgtn_pkg::LATCH_IDX_RST;
            r_tone      <= '0;
            r_nper      <= '0;
            r_noise_reg <= '0;
            r_vol       <= {psgtn_pkg::NUM_CHAN{psgtn_pkg::VOL_OFF}};
        end else begin
            r_latched   <= n_latched;
            r_tone      <= n_tone;
            r_nper      <= n_nper;
            r_noise_reg <= n_noise_reg;
            r_vol       <= n_vol;
        end
    end

    assign o_ctrl.tone_period  = r_tone;
    assign o_ctrl.noise_period = r_nper;
    assign o_ctrl.tap_b_en     = r_noise_reg[2];
    assign o_ctrl.noise_load   = noise_load;
    assign o_vol_next          = n_vol;

endmodule

[rtl/psgtn_osc.sv]
module psgtn_osc #(
    parameter int DIVIDER = psgtn_pkg::DIVIDER_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_tick,
    input  psgtn_pkg::t_ctrl                   i_ctrl,
    input  logic [psgtn_pkg::CFG_W-1:0]        i_lfsr_mask,
    input  logic [psgtn_pkg::CFG_W-1:0]        i_tap_a,
    input  logic [psgtn_pkg::CFG_W-1:0]        i_tap_b,
    output logic [psgtn_pkg::NUM_CHAN-1:0]     o_level_next
);

    localparam int DivW = (DIVIDER > 1) ? $clog2(DIVIDER) : 1;
    localparam logic [DivW-1:0] DivReload = DivW'(DIVIDER - 1);

    logic [DivW-1:0]                                           r_div;
    logic [DivW-1:0]                                           n_div;
    logic [psgtn_pkg::NUM_CHAN-1:0][psgtn_pkg::CNT_W-1:0]      r_cnt;
    logic [psgtn_pkg::NUM_CHAN-1:0][psgtn_pkg::CNT_W-1:0]      n_cnt;
    logic [psgtn_pkg::NUM_CHAN-1:0]                            r_level;
    logic [psgtn_pkg::NUM_CHAN-1:0]                            n_level;
    logic [psgtn_pkg::CFG_W-1:0]                               r_shift;
    logic [psgtn_pkg::CFG_W-1:0]                               n_shift;
    logic                                                      step;
    logic                                                      fb_a;
    logic                                                      fb_b;

    // Divider, tone counters and noise shift register
    always_comb begin
        n_div   = r_div;
        n_cnt   = r_cnt;
        n_level = r_level;
        n_shift = r_shift;
        step    = 1'b0;
        fb_a    = |(r_shift & i_tap_a);
        fb_b    = (|(r_shift & i_tap_b)) & i_ctrl.tap_b_en;
        if (i_tick) begin
            if (r_div != '0) begin
                n_div = r_div - DivW'(1);
            end else begin
                n_div = DivReload;
                step  = 1'b1;
            end
        end
        if (step) begin
            for (int i = 0; i < psgtn_pkg::NUM_TONE; i++) begin
                if (r_cnt[i] <= psgtn_pkg::CNT_W'(1)) begin
                    n_level[i] = ~r_level[i];
                    n_cnt[i]   = psgtn_pkg::CNT_W'(i_ctrl.tone_period[i]);
                end else begin
                    n_cnt[i] = r_cnt[i] - psgtn_pkg::CNT_W'(1);
                end
            end
            if (r_cnt[3] <= psgtn_pkg::CNT_W'(1)) begin
                n_shift    = {1'b0, r_shift[psgtn_pkg::CFG_W-1:1]} |
                             ((fb_a ^ fb_b) ? i_lfsr_mask : '0);
                n_level[3] = n_shift[0];
                n_cnt[3]   = i_ctrl.noise_period;
            end else begin
                n_cnt[3] = r_cnt[3] - psgtn_pkg::CNT_W'(1);
            end
        end
        // noise register write reloads the shift register
        if (i_ctrl.noise_load) begin
            n_shift = i_lfsr_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div   <= DivReload;
            r_cnt   <= '0;
            r_level <= '0;
            r_shift <= psgtn_pkg::LFSR_MASK_RST;
        end else begin
            r_div   <= n_div;
            r_cnt   <= n_cnt;
            r_level <= n_level;
            r_shift <= n_shift;
        end
    end

    assign o_level_next = n_level;

endmodule

[rtl/psgtn_mix.sv]
module psgtn_mix (
    input  logic [psgtn_pkg::NUM_CHAN-1:0]                           i_level,
    input  logic [psgtn_pkg::NUM_CHAN-1:0][psgtn_pkg::CODE_W-1:0]    i_vol_code,
    output logic signed [psgtn_pkg::SAMPLE_W-1:0]                    o_sample
);

    logic [psgtn_pkg::SUM_W-1:0] sum;

    // Sum of the active channel volumes, negated
    always_comb begin
        sum = '0;
        for (int i = 0; i < psgtn_pkg::NUM_CHAN; i++) begin
            if (i_level[i]) begin
                sum = sum + psgtn_pkg::SUM_W'(psgtn_pkg::vol_level(i_vol_code[i]));
            end
        end
        o_sample = psgtn_pkg::SAMPLE_W'(0) - psgtn_pkg::SAMPLE_W'(sum);
    end

endmodule

[rtl/psg_tone_noise_generator.sv]
// Sound generator with three square tone channels and one noise channel
// fed by a 16-bit feedback shift register. Each input request is either a
// chip byte (tuser 0) or one native sample tick (tuser 1); every request
// yields exactly one output sample, the negated sum of the volumes of the
// channels whose level is high. One request is taken per clock cycle and its
// sample appears in the output register on the next cycle; the only limit on
// throughput is the output register, which takes a new sample in the same
// cycle the held one is taken. Channel counters step once every DIVIDER
// ticks. The configuration port sets the shift register load/feedback mask
// and the two tap masks; write it only while no request is in flight.
module psg_tone_noise_generator #(
    parameter int DIVIDER = psgtn_pkg::DIVIDER_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [psgtn_pkg::DATA_W-1:0]          s_axis_tdata,   // [7:0] data_byte
    input  logic                                  s_axis_tuser,   // [0] kind
    // output stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [psgtn_pkg::SAMPLE_W-1:0]        m_axis_tdata,   // [15:0] sample
    // configuration write port
    input  logic                                  i_cfg_wr_en,
    input  logic [1:0]                            i_cfg_index,
    input  logic [psgtn_pkg::CFG_W-1:0]           i_cfg_data
);

    logic                                                     s_fire;
    logic                                                     wr_req;
    logic                                                     tick_req;
    psgtn_pkg::t_ctrl                                         ctrl;
    logic [psgtn_pkg::NUM_CHAN-1:0][psgtn_pkg::CODE_W-1:0]    vol_next;
    logic [psgtn_pkg::NUM_CHAN-1:0]                           level_next;
    logic signed [psgtn_pkg::SAMPLE_W-1:0]                    sample_next;

    logic [psgtn_pkg::CFG_W-1:0]                              r_lfsr_mask;
    logic [psgtn_pkg::CFG_W-1:0]                              r_tap_a;
    logic [psgtn_pkg::CFG_W-1:0]                              r_tap_b;
    logic                                                     r_m_valid;
    logic [psgtn_pkg::SAMPLE_W-1:0]                           r_m_data;

    // Request acceptance
    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign wr_req        = s_fire && (s_axis_tuser == psgtn_pkg::KIND_WRITE);
    assign tick_req      = s_fire && (s_axis_tuser == psgtn_pkg::KIND_TICK);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr_mask <= psgtn_pkg::LFSR_MASK_RST;
            r_tap_a     <= psgtn_pkg::TAP_A_RST;
            r_tap_b     <= psgtn_pkg::TAP_B_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                psgtn_pkg::CFG_LFSR_MASK: r_lfsr_mask <= i_cfg_data;
                psgtn_pkg::CFG_TAP_A:     r_tap_a     <= i_cfg_data;
                psgtn_pkg::CFG_TAP_B:     r_tap_b     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    psgtn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (wr_req),
        .i_data     (s_axis_tdata),
        .o_ctrl     (ctrl),
        .o_vol_next (vol_next)
    );

    psgtn_osc #(
        .DIVIDER (DIVIDER)
    ) u_osc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (tick_req),
        .i_ctrl       (ctrl),
        .i_lfsr_mask  (r_lfsr_mask),
        .i_tap_a      (r_tap_a),
        .i_tap_b      (r_tap_b),
        .o_level_next (level_next)
    );

    psgtn_mix u_mix (
        .i_level    (level_next),
        .i_vol_code (vol_next),
        .o_sample   (sample_next)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s_fire) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_m_data <= sample_next;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // Every accepted request leaves a sample waiting
    a_fire_gives_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> m_axis_tvalid)
        else $error("accepted request produced no sample");

    // Samples are never positive
    a_sample_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[psgtn_pkg::SAMPLE_W-1] || m_axis_tdata == '0))
        else $error("positive output sample");

    // An empty output register never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output register");

endmodule
